@@ rtl/core/gis_pkg.sv @@
// Shared types and constants for the greedy independent set block.
// Item field layout, LCG constants and the controller/datapath command bus.
// No dependencies.
package gis_pkg;

  // Default and upper bound of the vertex count.
  localparam int NUM_VERTICES_DEF = 64;

  // Fixed field widths.
  localparam int VTX_W  = 6;   // vertex number, position
  localparam int CNT_W  = 7;   // vertex count, set size, loop index
  localparam int NBR_W  = 64;  // neighbour mask
  localparam int LCG_W  = 32;  // seed, LCG state

  // Input tdata: row, neighbours, seed (lowest bit first), zero padded.
  localparam int ROW_LSB    = 0;
  localparam int NBR_LSB    = ROW_LSB + VTX_W;
  localparam int SEED_LSB   = NBR_LSB + NBR_W;
  localparam int IN_USED_W  = SEED_LSB + LCG_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata: vertex, position, set_size, final_seed, zero padded.
  localparam int VTX_LSB     = 0;
  localparam int POS_LSB     = VTX_LSB + VTX_W;
  localparam int SIZE_LSB    = POS_LSB + VTX_W;
  localparam int FSEED_LSB   = SIZE_LSB + CNT_W;
  localparam int OUT_USED_W  = FSEED_LSB + LCG_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = CNT_W'(64);

  // Item kinds carried in tuser.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // Linear congruential generator.
  localparam logic [LCG_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [LCG_W-1:0] LCG_ADD = 32'd1013904223;

  // Remainder bits resolved per cycle by the modulo unit.
  localparam int MOD_BITS = 4;

  typedef enum logic {
    OWA_IDX,
    OWA_J
  } ord_wa_t;

  typedef enum logic [1:0] {
    OWD_IDX,
    OWD_RDA,
    OWD_RDB
  } ord_wd_t;

  typedef struct packed {
    logic             adj_wr;     // store an adjacency row from the input item
    logic             seed_ld;    // load the LCG from the input seed
    logic             lcg_step;   // advance the LCG one step
    logic             mod_start;  // start lcg mod (idx + 1)
    logic             ord_rd;     // read visit order at idx (port A) and j (port B)
    logic             ord_wr;     // write visit order
    ord_wa_t          ord_wa;
    ord_wd_t          ord_wd;
    logic             scan_init;  // set free mask to the first n vertices, clear count
    logic             vtx_take;   // take the vertex on port A, fetch its row
    logic             adj_clear;  // drop the fetched neighbours from the free mask
    logic             ch_rd;      // read the chosen list at idx
    logic             out_ld;     // load the output register
    logic [CNT_W-1:0] idx;
    logic [CNT_W-1:0] n;
  } gis_cmd_t;

  typedef struct packed {
    logic             mod_done;
    logic             vtx_free;
    logic             out_free;
    logic [CNT_W-1:0] set_size;
  } gis_sts_t;

endpackage

@@ rtl/core/gis_mod.sv @@
// Multi-cycle modulo unit: 32-bit dividend by a divisor of at most 64.
// Restoring division, MOD_BITS remainder bits a cycle. Depends on gis_pkg.
module gis_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gis_pkg::LCG_W-1:0]  dividend,
  input  logic [gis_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [gis_pkg::VTX_W-1:0]  rem
);
  import gis_pkg::*;

  localparam int STEPS = LCG_W / MOD_BITS;
  localparam int CW    = $clog2(STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [LCG_W-1:0] dvd_r;
  logic [CNT_W-1:0] div_r;
  logic [CNT_W-1:0] rem_r;
  logic [LCG_W-1:0] dvd_nxt;
  logic [CNT_W-1:0] rem_nxt;

  // Shift in MOD_BITS dividend bits, subtract where the partial remainder allows.
  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    for (int k = 0; k < MOD_BITS; k++) begin
      rem_nxt = {rem_nxt[CNT_W-2:0], dvd_nxt[LCG_W-1]};
      dvd_nxt = {dvd_nxt[LCG_W-2:0], 1'b0};
      if (rem_nxt >= div_r) begin
        rem_nxt = rem_nxt - div_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r[VTX_W-1:0];

endmodule

@@ rtl/core/gis_dpath.sv @@
// Datapath: adjacency, visit order and chosen-list memories, LCG, free mask
// and output register. Instantiates gis_mod; depends on gis_pkg.
module gis_dpath #(
  parameter int NUM_VERTICES = gis_pkg::NUM_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gis_pkg::gis_cmd_t               cmd,
  output gis_pkg::gis_sts_t               sts,
  input  logic [gis_pkg::VTX_W-1:0]       in_row,
  input  logic [gis_pkg::NBR_W-1:0]       in_neighbours,
  input  logic [gis_pkg::LCG_W-1:0]       in_seed,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gis_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import gis_pkg::*;

  localparam int AW = $clog2(NUM_VERTICES);

  logic [NUM_VERTICES-1:0] adj_mem [NUM_VERTICES];
  logic [AW-1:0]           ord_mem [NUM_VERTICES];
  logic [AW-1:0]           ch_mem  [NUM_VERTICES];

  logic [LCG_W-1:0]        lcg_r;
  logic [LCG_W-1:0]        lcg_nxt;
  logic [NUM_VERTICES-1:0] free_r;
  logic [NUM_VERTICES-1:0] free_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [AW-1:0]           ord_rda_r;
  logic [AW-1:0]           ord_rdb_r;
  logic [NUM_VERTICES-1:0] adj_rd_r;
  logic [AW-1:0]           ch_rd_r;

  logic                    out_valid_r;
  logic [VTX_W-1:0]        out_vertex_r;
  logic [VTX_W-1:0]        out_pos_r;
  logic [CNT_W-1:0]        out_size_r;
  logic                    out_last_r;
  logic [LCG_W-1:0]        out_fseed_r;

  logic [AW-1:0]           ia;
  logic [AW-1:0]           ja;
  logic [AW-1:0]           ord_waddr;
  logic [AW-1:0]           ord_wdata;
  logic [CNT_W-1:0]        divisor;
  logic [VTX_W-1:0]        mod_rem;
  logic                    mod_done;
  logic                    row_ok;

  assign ia      = cmd.idx[AW-1:0];
  assign ja      = mod_rem[AW-1:0];
  assign divisor = cmd.idx + CNT_W'(1);
  assign row_ok  = CNT_W'(in_row) < CNT_W'(NUM_VERTICES);

  gis_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (lcg_r),
    .divisor  (divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Visit order write select
  always_comb begin
    ord_waddr = (cmd.ord_wa == OWA_J) ? ja : ia;
    case (cmd.ord_wd)
      OWD_RDA: ord_wdata = ord_rda_r;
      OWD_RDB: ord_wdata = ord_rdb_r;
      default: ord_wdata = ia;
    endcase
  end

  // LCG and free mask next values
  always_comb begin
    lcg_nxt = lcg_r;
    if (cmd.seed_ld) begin
      lcg_nxt = in_seed;
    end else if (cmd.lcg_step) begin
      lcg_nxt = lcg_r * LCG_MUL + LCG_ADD;
    end

    free_nxt = free_r;
    if (cmd.scan_init) begin
      for (int k = 0; k < NUM_VERTICES; k++) begin
        free_nxt[k] = CNT_W'(k) < cmd.n;
      end
    end else if (cmd.vtx_take) begin
      free_nxt[ord_rda_r] = 1'b0;
    end else if (cmd.adj_clear) begin
      free_nxt = free_r & ~adj_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_r       <= '0;
      free_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lcg_r  <= lcg_nxt;
      free_r <= free_nxt;
      if (cmd.scan_init) begin
        count_r <= '0;
      end else if (cmd.vtx_take) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Memories and their registered read ports
  always_ff @(posedge clk) begin
    if (cmd.adj_wr && row_ok) begin
      adj_mem[in_row[AW-1:0]] <= in_neighbours[NUM_VERTICES-1:0];
    end
    if (cmd.vtx_take) begin
      adj_rd_r <= adj_mem[ord_rda_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ord_wr) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (cmd.ord_rd) begin
      ord_rda_r <= ord_mem[ia];
      ord_rdb_r <= ord_mem[ja];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vtx_take) begin
      ch_mem[count_r[AW-1:0]] <= ord_rda_r;
    end
    if (cmd.ch_rd) begin
      ch_rd_r <= ch_mem[ia];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_vertex_r <= VTX_W'(ch_rd_r);
      out_pos_r    <= cmd.idx[VTX_W-1:0];
      out_size_r   <= count_r;
      out_last_r   <= (cmd.idx + CNT_W'(1)) == count_r;
      out_fseed_r  <= lcg_r;
    end
  end

  assign sts.mod_done = mod_done;
  assign sts.vtx_free = free_r[ord_rda_r];
  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.set_size = count_r;

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_fseed_r, out_size_r, out_pos_r, out_vertex_r};

endmodule

@@ rtl/core/gis_ctrl.sv @@
// Controller state machine: shuffle, scan and emit sequencing with the loop
// index and the clamped vertex count. Depends on gis_pkg.
module gis_ctrl #(
  parameter int NUM_VERTICES = gis_pkg::NUM_VERTICES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_kind,
  output logic                      in_tready,
  input  logic [gis_pkg::CNT_W-1:0] vertex_count,
  input  gis_pkg::gis_sts_t         sts,
  output gis_pkg::gis_cmd_t         cmd
);
  import gis_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_LCG,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_SW_RD,
    ST_SW_WI,
    ST_SW_WJ,
    ST_SC_INIT,
    ST_SC_RD,
    ST_SC_CHK,
    ST_SC_ADJ,
    ST_EM_RD,
    ST_EM_LD
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] n_sat;
  logic             scan_end;

  assign n_sat    = (vertex_count > CNT_W'(NUM_VERTICES)) ? CNT_W'(NUM_VERTICES) : vertex_count;
  assign scan_end = idx_r == (n_r - CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.idx   = idx_r;
    cmd.n     = n_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_kind == KIND_LOAD) begin
            cmd.adj_wr = 1'b1;
          end else begin
            cmd.seed_ld = 1'b1;
            n_nxt       = n_sat;
            idx_nxt     = '0;
            if (n_sat != '0) begin
              state_nxt = ST_INIT;
            end
          end
        end
      end
      ST_INIT: begin
        cmd.ord_wr = 1'b1;
        cmd.ord_wa = OWA_IDX;
        cmd.ord_wd = OWD_IDX;
        if (scan_end) begin
          // idx already holds n-1, the first shuffle position
          state_nxt = (n_r == CNT_W'(1)) ? ST_SC_INIT : ST_LCG;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_LCG: begin
        cmd.lcg_step = 1'b1;
        state_nxt    = ST_MOD_GO;
      end
      ST_MOD_GO: begin
        cmd.mod_start = 1'b1;
        state_nxt     = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (sts.mod_done) begin
          state_nxt = ST_SW_RD;
        end
      end
      ST_SW_RD: begin
        cmd.ord_rd = 1'b1;
        state_nxt  = ST_SW_WI;
      end
      ST_SW_WI: begin
        cmd.ord_wr = 1'b1;
        cmd.ord_wa = OWA_IDX;
        cmd.ord_wd = OWD_RDB;
        state_nxt  = ST_SW_WJ;
      end
      ST_SW_WJ: begin
        cmd.ord_wr = 1'b1;
        cmd.ord_wa = OWA_J;
        cmd.ord_wd = OWD_RDA;
        if (idx_r == CNT_W'(1)) begin
          state_nxt = ST_SC_INIT;
        end else begin
          idx_nxt   = idx_r - CNT_W'(1);
          state_nxt = ST_LCG;
        end
      end
      ST_SC_INIT: begin
        cmd.scan_init = 1'b1;
        idx_nxt       = '0;
        state_nxt     = ST_SC_RD;
      end
      ST_SC_RD: begin
        cmd.ord_rd = 1'b1;
        state_nxt  = ST_SC_CHK;
      end
      ST_SC_CHK, ST_SC_ADJ: begin
        if (state_r == ST_SC_CHK && sts.vtx_free) begin
          cmd.vtx_take = 1'b1;
          state_nxt    = ST_SC_ADJ;
        end else begin
          cmd.adj_clear = state_r == ST_SC_ADJ;
          if (scan_end) begin
            idx_nxt   = '0;
            state_nxt = ST_EM_RD;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_SC_RD;
          end
        end
      end
      ST_EM_RD: begin
        cmd.ch_rd = 1'b1;
        state_nxt = ST_EM_LD;
      end
      ST_EM_LD: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          if ((idx_r + CNT_W'(1)) == sts.set_size) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_EM_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      n_r     <= n_nxt;
    end
  end

endmodule

@@ rtl/core/greedy_independent_set.sv @@
// Top level of the greedy independent set block: configuration register,
// controller and datapath. Depends on gis_pkg, gis_ctrl and gis_dpath.
//
// Usage: load the graph first with kind 0 items (tuser low), one per row:
// tdata carries the row number and its neighbour mask. A load item gives no
// result. A kind 1 item (tuser high) carries a seed and runs the selection
// over the first vertex_count vertices (clamped to NUM_VERTICES): the LCG
// shuffles the visit order, the scan takes every vertex still free, and one
// result item per chosen vertex leaves on the out_ channel in order of
// selection, tlast on the final one, each with its position, the set size
// and the final LCG state. A vertex count of zero loads the seed and gives
// no result. A run with n vertices first fills the visit order, then makes
// n-1 shuffle steps, each an LCG step and a modulo by the modulo unit
// (four remainder bits a cycle over a 32-bit value); the scan reads and
// checks each vertex in visit order and clears the neighbours of each
// chosen one, and each result is read from the chosen list into the
// output register. One item is worked at a time; in_tready is high only
// between runs. A stalled receiver holds the result in the output register
// and pauses the emit sequence. Reset sets vertex_count to 64 and returns
// to idle; the adjacency rows must be loaded again before a run.
module greedy_independent_set #(
  parameter int NUM_VERTICES = gis_pkg::NUM_VERTICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input item
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gis_pkg::IN_TDATA_W-1:0]   in_tdata,   // row, neighbours, seed
  input  logic                             in_tuser,   // kind
  // result item
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gis_pkg::OUT_TDATA_W-1:0]  out_tdata,  // vertex, position, set_size, final_seed
  output logic                             out_tlast,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gis_pkg::CFG_AW-1:0]       paddr,
  input  logic [gis_pkg::CFG_DW-1:0]       pwdata,
  output logic [gis_pkg::CFG_DW-1:0]       prdata,
  output logic                             pready
);
  import gis_pkg::*;

  logic [CNT_W-1:0] vcount_r;
  logic             cfg_wr;
  logic [0:0]       reg_idx;
  gis_cmd_t         cmd;
  gis_sts_t         sts;

  // Register index comes from the word address.
  assign reg_idx = paddr[CFG_AW-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VERTEX_COUNT_RST;
    end else if (cfg_wr && reg_idx == REG_VERTEX_COUNT) begin
      vcount_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_VERTEX_COUNT) ? CFG_DW'(vcount_r) : '0;

  gis_ctrl #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_kind      (in_tuser),
    .in_tready    (in_tready),
    .vertex_count (vcount_r),
    .sts          (sts),
    .cmd          (cmd)
  );

  gis_dpath #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_row        (in_tdata[ROW_LSB +: VTX_W]),
    .in_neighbours (in_tdata[NBR_LSB +: NBR_W]),
    .in_seed       (in_tdata[SEED_LSB +: LCG_W]),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast)
  );

endmodule

@@ sim/greedy_independent_set_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for greedy_independent_set: loads graphs, runs seeded
// selections under random stalls on both streams and checks every chosen vertex
// against a behavioral predictor or a typed pick. Depends on gis_pkg and the block's RTL.
module greedy_independent_set_tb;
  import gis_pkg::*;

  localparam int NV          = NUM_VERTICES_DEF;
  // Longest run: a bound per vertex for shuffle and scan, one per chosen vertex, and a margin.
  localparam int RUN_CYCLES  = 17 * NV + 3 * NV + 32;
  localparam int STALL_LIMIT = 10000;
  localparam int ITEM_TARGET = 400;
  localparam int MAX_IDLE    = 12;
  localparam int SHOW_LIMIT  = 10;
  localparam logic [CFG_AW-1:0] COUNT_ADDR = CFG_AW'(4 * int'(REG_VERTEX_COUNT));

  // One chosen vertex as it leaves the result stream.
  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [VTX_W-1:0] position;
    logic [CNT_W-1:0] set_size;
    logic             last;
    logic [LCG_W-1:0] fseed;
  } pick_t;

  // Directed steps: register write, row load or selection run.
  typedef enum logic [1:0] {OP_COUNT, OP_LOAD, OP_RUN} step_op_t;
  // How a run is checked: by the predictor, no result at all, or one typed pick.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

  typedef struct packed {
    step_op_t         op;
    logic [CNT_W-1:0] arg;        // vertex count or row
    logic [NBR_W-1:0] nb;
    logic [LCG_W-1:0] seed;
    chk_t             chk;
    logic [VTX_W-1:0] pick_vtx;
    logic [LCG_W-1:0] pick_seed;
  } step_t;

  // A single vertex needs no shuffle step, so its pick and seed are known
  // by inspection; everything larger goes through the predictor.
  localparam step_t DIRECTED [20] = '{
    '{OP_COUNT, 7'd1,  64'd0,                  32'd0,          CHK_MODEL, 6'd0, 32'd0},
    // full mask on row 0: self loop and bits beyond the vertex count
    '{OP_LOAD,  7'd0,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, CHK_MODEL, 6'd0, 32'd0},
    '{OP_RUN,   7'd0,  64'd0,                  32'd0,          CHK_ONE,   6'd0, 32'd0},
    '{OP_RUN,   7'd63, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, CHK_ONE,   6'd0, 32'hFFFF_FFFF},
    // empty graph: the seed is taken, nothing comes out
    '{OP_COUNT, 7'd0,  64'd0,                  32'd0,          CHK_MODEL, 6'd0, 32'd0},
    '{OP_RUN,   7'd5,  64'd0,                  32'h1234_5678,  CHK_NONE,  6'd0, 32'd0},
    '{OP_COUNT, 7'd2,  64'd0,                  32'd0,          CHK_MODEL, 6'd0, 32'd0},
    '{OP_LOAD,  7'd1,  64'd0,                  32'd0,          CHK_MODEL, 6'd0, 32'd0},
    '{OP_RUN,   7'd0,  64'd0,                  32'd0,          CHK_MODEL, 6'd0, 32'd0},
    '{OP_LOAD,  7'd0,  64'd0,                  32'd0,          CHK_MODEL, 6'd0, 32'd0},
    '{OP_RUN,   7'd0,  64'd0,                  32'h8000_0000,  CHK_MODEL, 6'd0, 32'd0},
    '{OP_COUNT, 7'd5,  64'd0,                  32'd0,          CHK_MODEL, 6'd0, 32'd0},
    '{OP_LOAD,  7'd2,  64'h8,                  32'd0,          CHK_MODEL, 6'd0, 32'd0},
    '{OP_LOAD,  7'd3,  64'h4,                  32'd0,          CHK_MODEL, 6'd0, 32'd0},
    '{OP_LOAD,  7'd4,  64'hF,                  32'd0,          CHK_MODEL, 6'd0, 32'd0},
    '{OP_LOAD,  7'd0,  64'h11,                 32'd0,          CHK_MODEL, 6'd0, 32'd0},
    '{OP_LOAD,  7'd1,  64'hFFFF_0000_0000_0010, 32'd0,         CHK_MODEL, 6'd0, 32'd0},
    '{OP_RUN,   7'd0,  64'd0,                  32'd1,          CHK_MODEL, 6'd0, 32'd0},
    '{OP_RUN,   7'd0,  64'd0,                  32'hDEAD_BEEF,  CHK_MODEL, 6'd0, 32'd0},
    '{OP_RUN,   7'd0,  64'd0,                  32'hFFFF_FFFF,  CHK_MODEL, 6'd0, 32'd0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [IN_TDATA_W-1:0] in_tdata;    // row, neighbours, seed
  logic out_tvalid, out_tready, out_tlast;
  logic [OUT_TDATA_W-1:0] out_tdata;  // vertex, position, set_size, final_seed
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;

  // Predictor state: graph copy and the vertex count last written.
  logic [NBR_W-1:0] adj_copy [NV];
  logic [CNT_W-1:0] cfg_count;
  pick_t            pending_picks [$];

  int unsigned items_sent   = 0;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_wait      = 0;
  logic        tx_idle_on   = 1'b1;
  logic        rx_idle_on   = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  greedy_independent_set #(.NUM_VERTICES(NV)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  function automatic void log_fail(input string what);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("%0t: %s", $time, what);
  endfunction

  function automatic string describe(input pick_t p);
    return $sformatf("vertex %0d position %0d size %0d last %0b seed %h",
                     p.vertex, p.position, p.set_size, p.last, p.fseed);
  endfunction

  // Shuffle the visit order with the LCG, scan it greedily and queue one
  // pick per chosen vertex, in order of selection.
  task automatic predict_independent_set(input logic [LCG_W-1:0] seed);
    int unsigned      n, i, j, t;
    logic [LCG_W-1:0] x;
    logic [VTX_W-1:0] order [NV];
    logic [VTX_W-1:0] tmp;
    logic [NBR_W-1:0] avail;
    logic [VTX_W-1:0] chosen [$];
    pick_t            p;
    n = (cfg_count > NV) ? NV : cfg_count;
    x = seed;
    if (n != 0) begin
      for (i = 0; i < n; i++) order[i] = VTX_W'(i);
      for (i = n - 1; i > 0; i--) begin
        x = x * LCG_MUL + LCG_ADD;
        j = x % (i + 1);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      avail = (n >= NBR_W) ? '1 : ((NBR_W'(1) << n) - 1);
      for (t = 0; t < n; t++) begin
        if (avail[order[t]]) begin
          chosen.push_back(order[t]);
          avail[order[t]] = 1'b0;
          avail &= ~adj_copy[order[t]];
        end
      end
      for (t = 0; t < chosen.size(); t++) begin
        p.vertex   = chosen[t];
        p.position = VTX_W'(t);
        p.set_size = CNT_W'(chosen.size());
        p.last     = (t + 1 == chosen.size());
        p.fseed    = x;
        pending_picks.push_back(p);
      end
    end
  endtask

  // Offer one item after a random gap, hold it until accepted, then predict.
  task automatic send_item(input logic kind, input logic [VTX_W-1:0] row,
                           input logic [NBR_W-1:0] nb, input logic [LCG_W-1:0] seed,
                           input chk_t chk = CHK_MODEL,
                           input logic [VTX_W-1:0] pick_vtx = '0,
                           input logic [LCG_W-1:0] pick_seed = '0);
    logic [IN_TDATA_W-1:0] word;
    int unsigned           gap;
    pick_t                 p;
    word = '0;
    word[ROW_LSB +: VTX_W]  = row;
    word[NBR_LSB +: NBR_W]  = nb;
    word[SEED_LSB +: LCG_W] = seed;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (kind == KIND_LOAD) begin
      adj_copy[row] = nb;
    end else begin
      case (chk)
        CHK_MODEL: predict_independent_set(seed);
        CHK_ONE: begin
          p = '{vertex: pick_vtx, position: '0, set_size: CNT_W'(1), last: 1'b1,
                fseed: pick_seed};
          pending_picks.push_back(p);
        end
        default: ;  // the run gives no result
      endcase
    end
  endtask

  // Drop valid and hold until every pick has arrived; optionally let a
  // run that gives no result finish before touching the register.
  task automatic settle(input logic drain);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    if (drain) repeat (RUN_CYCLES) @(negedge clk);
  endtask

  // Write the vertex count with noise in the unused bits, then read it back.
  task automatic set_vertex_count(input logic [CNT_W-1:0] value);
    logic [CFG_DW-1:0] word, back;
    word = $urandom();
    word[CNT_W-1:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COUNT_ADDR;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    back = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_count = value;
    if (back[CNT_W-1:0] !== value)
      log_fail($sformatf("vertex_count read back %0d, written %0d", back[CNT_W-1:0], value));
  endtask

  // One phase: new vertex count, a fresh random graph, then a burst of runs
  // with the odd stray row load and the odd full drain in between.
  task automatic graph_phase(input logic [CNT_W-1:0] count_val);
    int unsigned      n, density, runs, u, v, r;
    logic [NBR_W-1:0] graph [NV];
    logic [LCG_W-1:0] seed;
    settle(1'b1);
    set_vertex_count(count_val);
    n = (count_val > NV) ? NV : count_val;
    tx_idle_on = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);
    density = $urandom_range(0, 16);
    for (u = 0; u < NV; u++) graph[u] = '0;
    for (u = 0; u < n; u++)
      for (v = u + 1; v < n; v++)
        if ($urandom_range(1, 16) <= density) begin
          graph[u][v] = 1'b1;
          graph[v][u] = 1'b1;
        end
    // Load every row in use so no run reads an unwritten row.
    for (u = 0; u < n; u++) begin
      case ($urandom_range(0, 7))
        0: graph[u] = {$urandom(), $urandom()};
        1: graph[u] |= ~((NBR_W'(1) << n) - 1) | (NBR_W'(1) << u);
        default: ;
      endcase
      send_item(KIND_LOAD, VTX_W'(u), graph[u], $urandom());
    end
    runs = (n > 32) ? $urandom_range(2, 3) : $urandom_range(4, 12);
    for (r = 0; r < runs; r++) begin
      case ($urandom_range(0, 9))
        0: send_item(KIND_LOAD, VTX_W'($urandom_range(0, NV - 1)), {$urandom(), $urandom()},
                     $urandom());
        1: settle(1'b0);
        default: ;
      endcase
      case ($urandom_range(0, 15))
        0:       seed = '0;
        1:       seed = '1;
        default: seed = $urandom();
      endcase
      send_item(KIND_RUN, VTX_W'($urandom_range(0, NV - 1)), {$urandom(), $urandom()}, seed);
    end
  endtask

  // Receiver: stall for the drawn number of cycles, then accept.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Check each accepted result against the oldest pending pick.
  always @(posedge clk) begin
    pick_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.vertex   = out_tdata[VTX_LSB +: VTX_W];
      got.position = out_tdata[POS_LSB +: VTX_W];
      got.set_size = out_tdata[SIZE_LSB +: CNT_W];
      got.fseed    = out_tdata[FSEED_LSB +: LCG_W];
      got.last     = out_tlast;
      if (pending_picks.size() == 0) begin
        log_fail({"result with nothing pending: ", describe(got)});
      end else begin
        want = pending_picks.pop_front();
        if (got !== want)
          log_fail({"expected ", describe(want), ", got ", describe(got)});
      end
      rx_wait = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    end
  end

  // Watchdog: end the run when no item moves on either stream for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL greedy_independent_set");
      $finish;
    end
  end

  initial begin
    step_t       s;
    int unsigned k;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_LOAD;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    cfg_count = VERTEX_COUNT_RST;
    for (k = 0; k < NV; k++) adj_copy[k] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed steps: extremes, empty graph, self loops, stray high bits.
    for (k = 0; k < $size(DIRECTED); k++) begin
      s = DIRECTED[k];
      case (s.op)
        OP_COUNT: begin
          settle(1'b1);
          set_vertex_count(s.arg);
        end
        OP_LOAD: send_item(KIND_LOAD, s.arg[VTX_W-1:0], s.nb, s.seed);
        default: send_item(KIND_RUN, s.arg[VTX_W-1:0], s.nb, s.seed, s.chk, s.pick_vtx,
                           s.pick_seed);
      endcase
    end

    // Random phases: full size, oversize, empty and single vertex first,
    // then mostly small graphs with an occasional large one.
    graph_phase(CNT_W'(64));
    graph_phase(CNT_W'(127));
    graph_phase(CNT_W'(0));
    graph_phase(CNT_W'(1));
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0:       graph_phase(CNT_W'($urandom_range(64, 127)));
        1:       graph_phase(CNT_W'(0));
        2, 3:    graph_phase(CNT_W'($urandom_range(17, 63)));
        default: graph_phase(CNT_W'($urandom_range(2, 16)));
      endcase
    end

    settle(1'b1);
    if (fail_count == 0 && pending_picks.size() == 0) begin
      $display("PASS greedy_independent_set");
    end else begin
      $display("FAIL greedy_independent_set");
    end
    $finish;
  end

endmodule

@@ greedy_independent_set.f @@
rtl/core/gis_pkg.sv
rtl/core/gis_mod.sv
rtl/core/gis_dpath.sv
rtl/core/gis_ctrl.sv
rtl/core/greedy_independent_set.sv
sim/greedy_independent_set_tb.sv
